@@ sv/knn_pkg.sv @@
// Shared types and constants of the k-nearest-neighbour search unit.
// No dependencies.
package knn_pkg;
    localparam int MAX_ROWS      = 1024;
    localparam int MAX_COLS      = 32;
    localparam int MAX_NEIGHBORS = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int ROW_W         = 10;
    localparam int COL_W         = 5;
    localparam int NB_W          = 4;
    localparam int DIST_W        = 37;
    localparam int ADDR_W        = ROW_W + COL_W;

    typedef enum logic [1:0] {
        CMD_LOAD_EXAMPLE = 2'd0,
        CMD_LOAD_QUERY   = 2'd1,
        CMD_SEARCH       = 2'd2,
        CMD_READ         = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        CFG_ROWS      = 2'd0,
        CFG_COLS      = 2'd1,
        CFG_NEIGHBORS = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_NEIGHBOR = 1'b0,
        KIND_READ     = 1'b1
    } kind_t;

    typedef struct packed {
        logic [1:0]              command;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [15:0]      value;
    } in_item_t;

    typedef struct packed {
        logic                    kind;
        logic [ROW_W-1:0]        result_row;
        logic [DIST_W-1:0]       distance;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic                    valid;
        logic [DIST_W-1:0]       sq_dist;
        logic [ROW_W-1:0]        row;
    } entry_t;
endpackage

@@ sv/knn_squared_distance_search_unit.sv @@
// Top level of the k-nearest-neighbour search unit: stores, distance
// pipeline, sequencer and the chain of sorting cells. Depends on knn_pkg
// and knn_cell.
//
// Items enter on cmd with cmd_valid/cmd_stall and results leave on res with
// res_valid/res_stall; registers are written on cfg_valid/cfg_ready.
// A load gives no result. A distance read gives one result, which passes
// through the read state into the output register. A search walks every
// row in use, one element per cycle through a three-stage read, square and
// accumulate pipeline; once the pipeline has drained, its neighbours are
// offered one per cycle while res_stall is low. Each finished distance
// is inserted into a chain of sorting cells in the same cycle.
// Only one item is worked on at a time; cmd_stall is high while a search or
// read is in progress or while a result waits on res_stall. A stalled
// result is held in the output register.
// Reset clears the control state and restores the register defaults;
// stored distances read as zero until a search has covered their row.
module knn_squared_distance_search_unit
    import knn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  in_item_t    cmd,
    output logic        res_valid,
    input  logic        res_stall,
    output out_item_t   res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_READ  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [10:0] rows_reg;
    logic [5:0]  cols_reg;
    logic [4:0]  nbr_reg;

    logic signed [15:0] example_mem [0:MAX_ROWS*MAX_COLS-1];
    logic signed [15:0] query_reg [0:MAX_COLS-1];
    logic [DIST_W-1:0]  dist_mem [0:MAX_ROWS-1];

    logic [10:0] nr;
    logic [5:0]  nc;
    logic [4:0]  nk;
    logic [10:0] filled_reg;
    logic [ROW_W-1:0] nr_m1_reg;
    logic [COL_W-1:0] nc_m1_reg;
    logic [NB_W-1:0]  k_m1_reg;

    logic [ROW_W-1:0] r_reg;
    logic [COL_W-1:0] c_reg;
    logic [NB_W-1:0]  e_reg;

    logic               a_v_reg, a_first_reg, a_last_reg;
    logic [ROW_W-1:0]   a_row_reg;
    logic signed [15:0] ex_rd_reg, q_rd_reg;
    logic               b_v_reg, b_first_reg, b_last_reg;
    logic [ROW_W-1:0]   b_row_reg;
    logic [33:0]        prod_reg;
    logic               c_v_reg, c_last_reg;
    logic [ROW_W-1:0]   c_row_reg;
    logic [DIST_W-1:0]  acc_reg;

    logic signed [16:0] diff;
    logic signed [33:0] sq;

    logic [DIST_W-1:0] dist_rd_reg;
    logic              rd_hit_reg;
    logic [ROW_W-1:0]  rd_row_reg;

    logic      out_free;
    logic      accept;
    logic      last_elem;
    logic      do_insert;
    entry_t    cand;
    entry_t    cells [0:MAX_NEIGHBORS-1];
    logic      less [0:MAX_NEIGHBORS-1];

    logic      res_valid_reg;
    out_item_t res_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign nr = (rows_reg == 11'd0) ? 11'd1 :
                ((rows_reg > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : rows_reg);
    assign nc = (cols_reg == 6'd0) ? 6'd1 :
                ((cols_reg > 6'(MAX_COLS)) ? 6'(MAX_COLS) : cols_reg);
    always_comb
    begin
        nk = (nbr_reg == 5'd0) ? 5'd1 :
             ((nbr_reg > 5'(MAX_NEIGHBORS)) ? 5'(MAX_NEIGHBORS) : nbr_reg);
        if (11'(nk) > nr)
        begin
            nk = nr[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 11'd1024;
            cols_reg <= 6'd32;
            nbr_reg  <= 5'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROWS:      rows_reg <= cfg_data;
                CFG_COLS:      cols_reg <= cfg_data[5:0];
                CFG_NEIGHBORS: nbr_reg  <= cfg_data[4:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd.command == CMD_LOAD_EXAMPLE))
        begin
            example_mem[{cmd.row, cmd.col}] <= cmd.value;
        end
        if (accept && (cmd.command == CMD_LOAD_QUERY))
        begin
            query_reg[cmd.col] <= cmd.value;
        end
        ex_rd_reg <= example_mem[{r_reg, c_reg}];
        q_rd_reg  <= query_reg[c_reg];
        if (c_v_reg && c_last_reg)
        begin
            dist_mem[c_row_reg] <= acc_reg;
        end
        if (accept)
        begin
            dist_rd_reg <= dist_mem[cmd.row];
            rd_hit_reg  <= 11'(cmd.row) < filled_reg;
            rd_row_reg  <= cmd.row;
        end
    end

    assign last_elem = (c_reg == nc_m1_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.command == CMD_SEARCH))
                begin
                    state_next = ST_CALC;
                end
                else if (accept && (cmd.command == CMD_READ))
                begin
                    state_next = ST_READ;
                end
            end
            ST_CALC:
            begin
                if (last_elem && (r_reg == nr_m1_reg))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!a_v_reg && !b_v_reg && !c_v_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && (e_reg == k_m1_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign diff = 17'(ex_rd_reg) - 17'(q_rd_reg);
    assign sq   = diff * diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            e_reg         <= '0;
            nr_m1_reg     <= '0;
            nc_m1_reg     <= '0;
            k_m1_reg      <= '0;
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_v_reg   <= (state_reg == ST_CALC);
            b_v_reg   <= a_v_reg;
            c_v_reg   <= b_v_reg;
            if (((state_reg == ST_EMIT) || (state_reg == ST_READ)) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                res_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_IDLE) && accept && (cmd.command == CMD_SEARCH))
            begin
                r_reg     <= '0;
                c_reg     <= '0;
                e_reg     <= '0;
                nr_m1_reg <= ROW_W'(nr - 11'd1);
                nc_m1_reg <= COL_W'(nc - 6'd1);
                k_m1_reg  <= NB_W'(nk - 5'd1);
                if (nr > filled_reg)
                begin
                    filled_reg <= nr;
                end
            end
            if (state_reg == ST_CALC)
            begin
                if (last_elem)
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                e_reg <= e_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_first_reg <= (c_reg == '0);
        a_last_reg  <= last_elem;
        a_row_reg   <= r_reg;
        b_first_reg <= a_first_reg;
        b_last_reg  <= a_last_reg;
        b_row_reg   <= a_row_reg;
        prod_reg    <= sq[33:0];
        c_last_reg  <= b_last_reg;
        c_row_reg   <= b_row_reg;
        acc_reg     <= b_first_reg ? DIST_W'(prod_reg) : acc_reg + DIST_W'(prod_reg);
        if ((state_reg == ST_EMIT) && out_free)
        begin
            res_reg.kind       <= KIND_NEIGHBOR;
            res_reg.result_row <= cells[e_reg].row;
            res_reg.distance   <= cells[e_reg].sq_dist;
            res_reg.last       <= (e_reg == k_m1_reg);
        end
        else if ((state_reg == ST_READ) && out_free)
        begin
            res_reg.kind       <= KIND_READ;
            res_reg.result_row <= rd_row_reg;
            res_reg.distance   <= rd_hit_reg ? dist_rd_reg : '0;
            res_reg.last       <= 1'b1;
        end
    end

    assign do_insert    = c_v_reg && c_last_reg;
    assign cand.valid   = do_insert;
    assign cand.sq_dist = acc_reg;
    assign cand.row     = c_row_reg;

    for (genvar i = 0; i < MAX_NEIGHBORS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            knn_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (accept && (cmd.command == CMD_SEARCH)),
                .insert     (do_insert),
                .cand       (cand),
                .prev_entry (cand),
                .prev_less  (1'b0),
                .entry      (cells[i]),
                .less       (less[i])
            );
        end
        else
        begin : g_body
            knn_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (accept && (cmd.command == CMD_SEARCH)),
                .insert     (do_insert),
                .cand       (cand),
                .prev_entry (cells[i-1]),
                .prev_less  (less[i-1]),
                .entry      (cells[i]),
                .less       (less[i])
            );
        end
    end

    a_emit_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> cells[0].valid)
        else $error("Neighbour chain empty at emission.");

    a_chain_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && cells[1].valid) |-> (cells[0].sq_dist <= cells[1].sq_dist))
        else $error("Neighbour chain out of order.");

    a_insert_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |-> (state_reg == ST_CALC || state_reg == ST_DRAIN))
        else $error("Distance finished outside a search.");
endmodule

@@ sv/knn_cell.sv @@
// One cell of the sorted neighbour chain: holds one candidate, which a clear
// empties; on an insertion it may take the new candidate or its upper neighbour's.
// Depends on knn_pkg.
module knn_cell
    import knn_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   clear,
    input  logic   insert,
    input  entry_t cand,
    input  entry_t prev_entry,
    input  logic   prev_less,
    output entry_t entry,
    output logic   less
);
    entry_t entry_reg;
    entry_t entry_next;

    assign less  = cand.valid && (!entry_reg.valid || (cand.sq_dist < entry_reg.sq_dist));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (clear)
        begin
            entry_next.valid = 1'b0;
        end
        else if (insert)
        begin
            if (prev_less)
            begin
                entry_next = prev_entry;
            end
            else if (less)
            begin
                entry_next = cand;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid   <= 1'b0;
            entry_reg.sq_dist <= '0;
            entry_reg.row     <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end
endmodule

@@ verif/tb_knn_squared_distance_search_unit.sv @@
// Self-checking testbench for knn_squared_distance_search_unit: directed items, then
// random loads, reads and searches under several register settings, checked against a
// local predictor of squared distances and neighbour order. Depends on knn_pkg and the RTL.
module tb_knn_squared_distance_search_unit;
    import knn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 150000;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    in_item_t    cmd = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    out_item_t   res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ROWS;
    logic [10:0] cfg_data = '0;

    logic signed [15:0] example_mem [MAX_ROWS*MAX_COLS];
    logic signed [15:0] query_mem [MAX_COLS];
    bit                 example_set [MAX_ROWS*MAX_COLS];
    bit                 query_set [MAX_COLS];
    longint unsigned    dist_mem [MAX_ROWS];
    int                 rows_reg = 1024;
    int                 cols_reg = 32;
    int                 nb_reg = 1;

    out_item_t awaited_results [$];
    dir_row_t  dir_rows [$];
    bit        failed = 1'b0;
    bit        calm = 1'b0;
    int        hold_left = 0;
    int        idle_count = 0;

    knn_squared_distance_search_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 15);
    endfunction

    function automatic int clamp_to(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_item_t mk(command_t c, int r, int cl, int v);
        in_item_t it;
        it.command = c;
        it.row = r[ROW_W-1:0];
        it.col = cl[COL_W-1:0];
        it.value = v[15:0];
        return it;
    endfunction

    function automatic void knn_apply(in_item_t it);
        int nr, nc, k, best, idx;
        longint signed d;
        longint unsigned acc;
        bit taken [MAX_ROWS];
        out_item_t o;
        case (it.command)
            CMD_LOAD_EXAMPLE:
            begin
                idx = int'(it.row) * MAX_COLS + int'(it.col);
                example_mem[idx] = it.value;
                example_set[idx] = 1'b1;
            end
            CMD_LOAD_QUERY:
            begin
                query_mem[it.col] = it.value;
                query_set[it.col] = 1'b1;
            end
            CMD_READ:
            begin
                o.kind = KIND_READ;
                o.result_row = it.row;
                o.distance = dist_mem[it.row][DIST_W-1:0];
                o.last = 1'b1;
                awaited_results.push_back(o);
            end
            default:
            begin
                nr = clamp_to(rows_reg, MAX_ROWS);
                nc = clamp_to(cols_reg, MAX_COLS);
                k = clamp_to(nb_reg, MAX_NEIGHBORS);
                if (k > nr)
                    k = nr;
                for (int r = 0; r < nr; r++)
                begin
                    acc = 0;
                    for (int c = 0; c < nc; c++)
                    begin
                        d = longint'(example_mem[r*MAX_COLS+c]) - longint'(query_mem[c]);
                        acc += longint'(d * d);
                    end
                    dist_mem[r] = acc;
                    taken[r] = 1'b0;
                end
                for (int i = 0; i < k; i++)
                begin
                    best = -1;
                    for (int r = 0; r < nr; r++)
                        if (!taken[r] && (best < 0 || dist_mem[r] < dist_mem[best]))
                            best = r;
                    taken[best] = 1'b1;
                    o.kind = KIND_NEIGHBOR;
                    o.result_row = best[ROW_W-1:0];
                    o.distance = dist_mem[best][DIST_W-1:0];
                    o.last = (i + 1 == k);
                    awaited_results.push_back(o);
                end
            end
        endcase
    endfunction

    task automatic send_cmd(in_item_t it);
        while (take_break())
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic issue(in_item_t it);
        send_cmd(it);
        knn_apply(it);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int data);
        drain();
        cfg_index <= idx;
        cfg_data <= data[10:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROWS:      rows_reg = data & 'h7FF;
            CFG_COLS:      cols_reg = data & 'h3F;
            CFG_NEIGHBORS: nb_reg = data & 'h1F;
            default: ;
        endcase
    endtask

    task automatic set_regs(int rows, int cols, int nbs);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        write_reg(CFG_NEIGHBORS, nbs);
    endtask

    // Every element a search will read must have been loaded beforehand.
    task automatic fill_for_search();
        int nr, nc;
        nr = clamp_to(rows_reg, MAX_ROWS);
        nc = clamp_to(cols_reg, MAX_COLS);
        for (int c = 0; c < nc; c++)
            if (!query_set[c])
                issue(mk(CMD_LOAD_QUERY, $urandom_range(1023), c, rand_sample()));
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (!example_set[r*MAX_COLS+c])
                    issue(mk(CMD_LOAD_EXAMPLE, r, c, rand_sample()));
    endtask

    task automatic random_items(int n);
        int nr, nc, pick;
        nr = clamp_to(rows_reg, MAX_ROWS);
        nc = clamp_to(cols_reg, MAX_COLS);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                if ($urandom_range(9) == 0)
                    issue(mk(CMD_LOAD_EXAMPLE, $urandom_range(1023), $urandom_range(31),
                             rand_sample()));
                else
                    issue(mk(CMD_LOAD_EXAMPLE, $urandom_range(nr - 1),
                             $urandom_range(nc - 1), rand_sample()));
            end
            else if (pick < 58)
                issue(mk(CMD_LOAD_QUERY, $urandom_range(1023), $urandom_range(31),
                         rand_sample()));
            else if (pick < 78)
                issue(mk(CMD_READ, $urandom_range(1023), $urandom_range(31), $urandom));
            else
            begin
                fill_for_search();
                issue(mk(CMD_SEARCH, $urandom_range(1023), $urandom_range(31), $urandom));
            end
        end
    endtask

    function automatic void add_row(in_item_t it, bit typed, longint unsigned want_dist);
        dir_row_t d;
        d.item = it;
        d.typed = typed;
        d.want.kind = KIND_READ;
        d.want.result_row = it.row;
        d.want.distance = want_dist[DIST_W-1:0];
        d.want.last = 1'b1;
        dir_rows.push_back(d);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)
                || (cfg_valid && cfg_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("tb_knn_squared_distance_search_unit failed");
                $finish;
            end
            if (res_valid && !res_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with nothing awaited: row %0d", res.result_row);
                    failed = 1'b1;
                end
                else
                begin
                    out_item_t w;
                    w = awaited_results.pop_front();
                    if (res.kind !== w.kind)
                    begin
                        $error("kind: expected %0d, got %0d", w.kind, res.kind);
                        failed = 1'b1;
                    end
                    if (res.result_row !== w.result_row)
                    begin
                        $error("result_row: expected %0d, got %0d", w.result_row,
                               res.result_row);
                        failed = 1'b1;
                    end
                    if (res.distance !== w.distance)
                    begin
                        $error("distance: expected %0d, got %0d", w.distance, res.distance);
                        failed = 1'b1;
                    end
                    if (res.last !== w.last)
                    begin
                        $error("last: expected %0d, got %0d", w.last, res.last);
                        failed = 1'b1;
                    end
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= take_break();
    end

    initial
    begin
        for (int r = 0; r < MAX_ROWS; r++)
            dist_mem[r] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(mk(CMD_READ, 0, 0, 0), 1'b1, 0);
        add_row(mk(CMD_READ, 1023, 31, -1), 1'b1, 0);
        foreach (dir_rows[i])
        begin
            issue(dir_rows[i].item);
            if (dir_rows[i].typed)
            begin
                void'(awaited_results.pop_back());
                awaited_results.push_back(dir_rows[i].want);
            end
        end
        dir_rows.delete();

        set_regs(4, 2, 16);
        add_row(mk(CMD_LOAD_QUERY, 0, 0, 32767), 1'b0, 0);
        add_row(mk(CMD_LOAD_QUERY, 0, 1, -32768), 1'b0, 0);
        add_row(mk(CMD_LOAD_EXAMPLE, 0, 0, 32767), 1'b0, 0);
        add_row(mk(CMD_LOAD_EXAMPLE, 0, 1, -32768), 1'b0, 0);
        add_row(mk(CMD_LOAD_EXAMPLE, 1, 0, -32768), 1'b0, 0);
        add_row(mk(CMD_LOAD_EXAMPLE, 1, 1, 32767), 1'b0, 0);
        add_row(mk(CMD_LOAD_EXAMPLE, 2, 0, 0), 1'b0, 0);
        add_row(mk(CMD_LOAD_EXAMPLE, 2, 1, 0), 1'b0, 0);
        add_row(mk(CMD_LOAD_EXAMPLE, 3, 0, 32767), 1'b0, 0);
        add_row(mk(CMD_LOAD_EXAMPLE, 3, 1, -32768), 1'b0, 0);
        add_row(mk(CMD_SEARCH, 1023, 31, -1), 1'b0, 0);
        add_row(mk(CMD_READ, 1, 0, 0), 1'b1, 64'd8589672450);
        add_row(mk(CMD_READ, 5, 0, 0), 1'b1, 0);
        add_row(mk(CMD_READ, 2, 0, 0), 1'b0, 0);
        add_row(mk(CMD_LOAD_EXAMPLE, 1023, 31, 1), 1'b0, 0);
        add_row(mk(CMD_SEARCH, 0, 0, 0), 1'b0, 0);
        foreach (dir_rows[i])
        begin
            issue(dir_rows[i].item);
            if (dir_rows[i].typed)
            begin
                void'(awaited_results.pop_back());
                awaited_results.push_back(dir_rows[i].want);
            end
        end

        set_regs(0, 0, 0);
        random_items(50);

        set_regs($urandom_range(2, 12), $urandom_range(1, 8), $urandom_range(1, 16));
        calm = 1'b1;
        random_items(80);
        calm = 1'b0;

        set_regs($urandom_range(8, 16), $urandom_range(1, 4), 16);
        fill_for_search();
        hold_left = 600;
        for (int i = 0; i < 6; i++)
            issue(mk(CMD_SEARCH, $urandom_range(1023), $urandom_range(31), $urandom));
        random_items(40);

        set_regs($urandom_range(1, 16), $urandom_range(1, 4), 31);
        random_items(60);
        drain();
        random_items(60);

        set_regs($urandom_range(1, 3), 63, $urandom_range(0, 20));
        random_items(60);

        set_regs(2, 63, 31);
        fill_for_search();
        issue(mk(CMD_SEARCH, $urandom_range(1023), $urandom_range(31), $urandom));
        for (int i = 0; i < 10; i++)
            issue(mk(CMD_READ, $urandom_range(1023), $urandom_range(31), $urandom));

        set_regs($urandom_range(1, 12), $urandom_range(1, 4), $urandom_range(1, 16));
        random_items(80);

        drain();
        repeat (20) @(posedge clk);
        if (!failed)
            $display("tb_knn_squared_distance_search_unit passed");
        else
            $display("tb_knn_squared_distance_search_unit failed");
        $finish;
    end
endmodule

@@ knn_squared_distance_search_unit.f @@
sv/knn_pkg.sv
sv/knn_cell.sv
sv/knn_squared_distance_search_unit.sv
verif/tb_knn_squared_distance_search_unit.sv
